// ----- src/dcpl_pkg.sv -----
// Shared types and constants for the dynamic common prefix length block.
// Used by dcpl_flags and dynamic_common_prefix_length; depends on nothing.
`default_nettype none

package dcpl_pkg;

    localparam int DEF_MAX_LEN = 1024;
    localparam int POS_W       = 11;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 11;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    // Match flags are kept in rows of this many bits.
    localparam int ROW_W  = 32;
    localparam int ROW_SH = 5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_SRCH,
        S_FIN
    } dcpl_state_t;

    typedef struct packed {
        logic clear;
        logic fetch;
        logic update;
        logic search;
        logic flag_value;
    } dcpl_ctrl_t;

endpackage

`default_nettype wire

// ----- src/dcpl_flags.sv -----
// Match flag store: a row memory of match flags plus a per-row summary register,
// with the first-mismatch search. Depends on dcpl_pkg.
`default_nettype none

module dcpl_flags
    import dcpl_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire dcpl_ctrl_t                                 ctrl,
    input  wire logic [((MAX_LEN + ROW_W - 1) / ROW_W > 1 ?
                        $clog2((MAX_LEN + ROW_W - 1) / ROW_W) : 1)-1:0] row,
    input  wire logic [ROW_SH-1:0]                          bit_sel,
    output logic [$clog2(((MAX_LEN + ROW_W - 1) / ROW_W) * ROW_W + 1)-1:0] first_miss
);

    localparam int NROWS = (MAX_LEN + ROW_W - 1) / ROW_W;
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int MW    = $clog2(NROWS * ROW_W + 1);

    logic [ROW_W-1:0] mem [NROWS];
    logic [ROW_W-1:0] row_q_reg;
    logic [ROW_W-1:0] new_row;
    logic [NROWS-1:0] summary_reg;
    logic [NROWS-1:0] summary_next;
    logic [RW-1:0]    hit_row_reg;
    logic [RW-1:0]    hit_row_next;
    logic             found_reg;
    logic             found_next;
    logic             zero_found;
    logic [RW-1:0]    zero_row;
    logic [ROW_SH-1:0] zero_bit;
    logic [RW-1:0]    rd_addr;

    always_comb
    begin
        zero_found = 1'b0;
        zero_row   = '0;
        for (int i = NROWS - 1; i >= 0; i--)
        begin
            if (!summary_reg[i])
            begin
                zero_found = 1'b1;
                zero_row   = RW'(i);
            end
        end
    end

    always_comb
    begin
        zero_bit = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (!row_q_reg[i])
            begin
                zero_bit = ROW_SH'(i);
            end
        end
    end

    always_comb
    begin
        new_row          = row_q_reg;
        new_row[bit_sel] = ctrl.flag_value;
    end

    assign rd_addr = ctrl.search ? zero_row : row;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            mem[row] <= '1;
        end
        else if (ctrl.update)
        begin
            mem[row] <= new_row;
        end
        if (ctrl.fetch || ctrl.search)
        begin
            row_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        summary_next = summary_reg;
        hit_row_next = hit_row_reg;
        found_next   = found_reg;
        if (ctrl.update)
        begin
            summary_next[row] = &new_row;
        end
        if (ctrl.search)
        begin
            hit_row_next = zero_row;
            found_next   = zero_found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg <= '1;
            hit_row_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            summary_reg <= summary_next;
            hit_row_reg <= hit_row_next;
            found_reg   <= found_next;
        end
    end

    assign first_miss = found_reg ? MW'({hit_row_reg, zero_bit}) : MW'(NROWS * ROW_W);

endmodule

`default_nettype wire

// ----- src/dynamic_common_prefix_length.sv -----
// Top level of the dynamic common prefix length block: character memory, control
// sequencer, length register and result register. Depends on dcpl_pkg and dcpl_flags.
//
//  Channel   Signals                               Transfer when
//  input     start, busy, mode, position, char_value   start high and busy low
//  config    cfg_we, cfg_data                      cfg_we high
//  result    done, prefix_length                   done high (one cycle)
//
// Each item is handled in steps, and busy stays high until the last of them. The accepting
// edge reads both memories, and then come write back (for a valid position), search of the
// row summary and search within the row; done and the result are registered at the end of
// that search. The character and flag memories each have a single read port.
// After reset a clearing pass runs with busy high; it zeroes every character entry and
// sets every match flag. The result side cannot stall; busy drops in the cycle that done
// is high, so the next transfer can be accepted at the edge that ends that cycle.
`default_nettype none

module dynamic_common_prefix_length
    import dcpl_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [CHAR_W-1:0] char_value,
    output logic                   done,
    output logic [LEN_W-1:0]       prefix_length,
    input  wire logic              cfg_we,
    input  wire logic [LEN_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int NROWS = (MAX_LEN + ROW_W - 1) / ROW_W;
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int MW    = $clog2(NROWS * ROW_W + 1);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CW0   = (MW > LW) ? MW : LW;
    localparam int CW    = (CW0 > LEN_W) ? CW0 : LEN_W;

    dcpl_state_t state_reg;
    dcpl_state_t state_next;

    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       idx_reg;
    logic                mode_reg;
    logic                valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                done_reg;
    logic [LEN_W-1:0]    result_reg;
    logic [LEN_W-1:0]    result_next;

    logic [2*CHAR_W-1:0] cmem [MAX_LEN];
    logic [2*CHAR_W-1:0] cdata_reg;
    logic [2*CHAR_W-1:0] cmem_wdata;
    logic [AW-1:0]       cmem_addr;
    logic                cmem_we;

    logic                accept;
    logic [CW-1:0]       pos_ext;
    logic                pos_valid;
    logic [AW-1:0]       idx_in;
    logic [CHAR_W-1:0]   new_a;
    logic [CHAR_W-1:0]   new_b;
    logic [RW-1:0]       flag_row;
    dcpl_ctrl_t          ctrl;
    logic [MW-1:0]       first_miss;
    logic [CW-1:0]       limit;
    logic [CW-1:0]       miss_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign pos_ext   = CW'(position);
    assign pos_valid = (pos_ext != '0) && (pos_ext <= CW'(MAX_LEN));
    assign idx_in    = AW'(pos_ext - CW'(1));

    assign new_a = mode_reg ? cdata_reg[2*CHAR_W-1:CHAR_W] : char_reg;
    assign new_b = mode_reg ? char_reg : cdata_reg[CHAR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAX_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:    state_next = S_SRCH;
            S_SRCH:  state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy            = (state_reg != S_IDLE);
        ctrl.clear      = (state_reg == S_CLEAR);
        ctrl.fetch      = accept;
        ctrl.update     = (state_reg == S_RD) && valid_reg;
        ctrl.search     = (state_reg == S_SRCH);
        ctrl.flag_value = (new_a == new_b);
        cmem_we         = ctrl.clear || ctrl.update;
        cmem_addr       = ctrl.clear ? clr_cnt_reg : idx_reg;
        cmem_wdata      = ctrl.clear ? '0 : {new_a, new_b};
        if (ctrl.clear)
        begin
            flag_row = RW'(32'(clr_cnt_reg) >> ROW_SH);
        end
        else if (accept)
        begin
            flag_row = RW'(32'(idx_in) >> ROW_SH);
        end
        else
        begin
            flag_row = RW'(32'(idx_reg) >> ROW_SH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
        begin
            cmem[cmem_addr] <= cmem_wdata;
        end
        if (accept)
        begin
            cdata_reg <= cmem[idx_in];
        end
    end

    dcpl_flags #(
        .MAX_LEN (MAX_LEN)
    ) u_flags (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .row        (flag_row),
        .bit_sel    (ROW_SH'(idx_reg)),
        .first_miss (first_miss)
    );

    always_comb
    begin
        limit    = (CW'(len_reg) > CW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(len_reg);
        miss_ext = CW'(first_miss);
        result_next = LEN_W'((miss_ext < limit) ? miss_ext : limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            len_reg     <= LEN_RESET;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            if (accept)
            begin
                valid_reg <= pos_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= idx_in;
            mode_reg <= mode;
            char_reg <= char_value;
        end
        if (state_reg == S_FIN)
        begin
            result_reg <= result_next;
        end
    end

    assign done          = done_reg;
    assign prefix_length = result_reg;

`ifndef ASSERT_OFF
    a_result_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prefix_length <= len_reg))
        else $error("prefix length exceeds the length in use");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_RD))
        else $error("accepted transfer did not start a read");

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_FIN))
        else $error("done strobe without a finished search");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for dynamic_common_prefix_length: queued character writes,
// a behavioral predictor of both strings and their match flags, and a result monitor.
// Depends on dcpl_pkg and the dynamic_common_prefix_length RTL.

module testbench;
    import dcpl_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;

    typedef struct {
        logic              m;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
    } char_write_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              mode;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_value;
    logic              done;
    logic [LEN_W-1:0]  prefix_length;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_data;

    char_write_t       write_queue[$];
    logic [LEN_W-1:0]  prefix_expected_q[$];
    char_write_t       next_write;
    logic [LEN_W-1:0]  want_prefix;
    logic              taken;
    int                idle_left;
    bit                sender_idle_on;
    int                mismatch_count;
    int                cycle_count;
    int                in_range_writes;

    // Predictor state, updated in transfer order.
    logic [CHAR_W-1:0] str_a [DEF_MAX_LEN];
    logic [CHAR_W-1:0] str_b [DEF_MAX_LEN];
    bit                match_bits [DEF_MAX_LEN];
    logic [LEN_W-1:0]  len_in_use;

    // Strings as they will stand once every queued write has been applied.
    logic [CHAR_W-1:0] plan_a [DEF_MAX_LEN];
    logic [CHAR_W-1:0] plan_b [DEF_MAX_LEN];

    dynamic_common_prefix_length #(
        .MAX_LEN(DEF_MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .position(position),
        .char_value(char_value),
        .done(done),
        .prefix_length(prefix_length),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [LEN_W-1:0] predict_prefix(input logic m,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [CHAR_W-1:0] ch);
        int idx;
        int lim;
        int n;
        if (pos >= 1 && pos <= DEF_MAX_LEN)
        begin
            idx = pos - 1;
            if (m)
                str_b[idx] = ch;
            else
                str_a[idx] = ch;
            match_bits[idx] = (str_a[idx] == str_b[idx]);
        end
        lim = (len_in_use > DEF_MAX_LEN) ? DEF_MAX_LEN : len_in_use;
        n = 0;
        while (n < lim && match_bits[n])
            n++;
        return n[LEN_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idle_on || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Driver: a transfer is seen at the rising edge, its prediction is made at the
    // following falling edge, where the next write is put on the ports unless an idle gap is due.
    always @(posedge clk)
    begin
        taken <= rst_n && start && !busy;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (taken)
                prefix_expected_q.push_back(predict_prefix(mode, position, char_value));
            if (start && !taken)
            begin
                start <= 1'b1;
            end
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (write_queue.size() > 0)
            begin
                next_write = write_queue.pop_front();
                mode       <= next_write.m;
                position   <= next_write.pos;
                char_value <= next_write.ch;
                start      <= 1'b1;
                idle_left  <= pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (prefix_expected_q.size() == 0)
            begin
                report_error($sformatf("result %0d with nothing pending", prefix_length));
            end
            else
            begin
                want_prefix = prefix_expected_q.pop_front();
                if (prefix_length !== want_prefix)
                    report_error($sformatf("prefix_length %0d, expected %0d",
                                           prefix_length, want_prefix));
            end
        end
    end

    task automatic queue_write(input logic m, input int pos, input int ch);
        char_write_t w;
        w.m   = m;
        w.pos = pos[POS_W-1:0];
        w.ch  = ch[CHAR_W-1:0];
        write_queue.push_back(w);
        if (pos >= 1 && pos <= DEF_MAX_LEN)
        begin
            in_range_writes++;
            if (m)
                plan_b[pos-1] = w.ch;
            else
                plan_a[pos-1] = w.ch;
        end
    endtask

    task automatic queue_random_write(input int window);
        int   r;
        int   pos;
        int   ch;
        logic m;
        r = $urandom_range(0, 99);
        m = 1'($urandom_range(0, 1));
        if (r < 8)
            pos = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(DEF_MAX_LEN + 1, POS_MAX);
        else if (r < 18)
            pos = $urandom_range(1, DEF_MAX_LEN);
        else if (r < 60)
            pos = $urandom_range(1, (window < 32) ? window : 32);
        else
            pos = $urandom_range(1, window);
        r = $urandom_range(0, 99);
        if (r < 45 && pos >= 1 && pos <= DEF_MAX_LEN)
            ch = m ? int'(plan_a[pos-1]) : int'(plan_b[pos-1]);
        else if (r < 70)
            ch = $urandom_range(0, 3);
        else
            ch = $urandom_range(0, 255);
        queue_write(m, pos, ch);
    endtask

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (write_queue.size() != 0 || start || prefix_expected_q.size() != 0 || busy);
    endtask

    task automatic write_length(input int v);
        wait_quiet();
        @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= v[LEN_W-1:0];
        len_in_use = v[LEN_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int k;
        int v;
        int eff;
        int window;
        int phase;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = 1'b0;
        position       = '0;
        char_value     = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        taken          = 1'b0;
        idle_left      = 0;
        sender_idle_on = 1'b1;
        mismatch_count = 0;
        cycle_count    = 0;
        len_in_use     = LEN_RESET;
        for (int i = 0; i < DEF_MAX_LEN; i++)
        begin
            str_a[i]      = '0;
            str_b[i]      = '0;
            plan_a[i]     = '0;
            plan_b[i]     = '0;
            match_bits[i] = 1'b1;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset contents and length, both ends of the store, ignored positions.
        queue_write(0, 1, 0);
        queue_write(0, DEF_MAX_LEN, 255);
        queue_write(1, DEF_MAX_LEN, 255);
        queue_write(1, 0, 8'hAA);
        queue_write(0, POS_MAX, 8'hFF);
        queue_write(1, DEF_MAX_LEN + 1, 8'h01);
        queue_write(0, 1, 8'h55);
        queue_write(1, 1, 8'h55);
        queue_write(1, 512, 8'h80);
        queue_write(0, 512, 8'h80);
        queue_write(0, 3, 8'h7F);

        write_length(0);
        queue_write(1, 3, 8'h7F);
        queue_write(0, 5, 8'h33);

        write_length(1);
        queue_write(0, 2, 8'h01);
        queue_write(0, 1, 8'hFE);
        queue_write(1, 1, 8'hFE);
        queue_write(1, 5, 8'h33);

        write_length(LEN_MAX);
        queue_write(0, 2, 8'h00);
        queue_write(0, 1023, 8'h10);
        queue_write(1, 1023, 8'h10);

        write_length(DEF_MAX_LEN + 1);
        queue_write(1, 700, 8'hC3);
        queue_write(0, 700, 8'hC3);

        in_range_writes = 0;
        phase = 0;
        while (in_range_writes < 1050)
        begin
            k = $urandom_range(0, 9);
            case (k)
                0: v = 0;
                1: v = 1;
                2: v = LEN_MAX;
                3: v = DEF_MAX_LEN;
                4: v = $urandom_range(DEF_MAX_LEN + 1, LEN_MAX - 1);
                default: v = $urandom_range(2, 64);
            endcase
            write_length(v);
            sender_idle_on = (phase % 3 != 0);
            eff    = (v > DEF_MAX_LEN) ? DEF_MAX_LEN : v;
            window = (eff < 4) ? 4 : eff;
            repeat ($urandom_range(40, 120))
                queue_random_write(window);
            phase++;
        end

        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/dcpl_pkg.sv
src/dcpl_flags.sv
src/dynamic_common_prefix_length.sv
sim/testbench.sv
